// File: rtl/gdn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gdn_pkg;

    localparam int YEAR_BITS_DEF      = 14;
    localparam int DAY_COUNT_BITS_DEF = 21;

    localparam int          MONTHS       = 12;
    localparam logic [3:0]  MARCH        = 4'd3;
    localparam logic [3:0]  FEBRUARY     = 4'd2;
    localparam logic [8:0]  CYCLE_YEARS  = 9'd400;
    localparam logic [8:0]  DAYS_LEAP    = 9'd366;
    localparam logic [8:0]  DAYS_COMMON  = 9'd365;
    localparam int          YEAR_BIAS    = 1900;
    localparam int          TWO_DIGIT    = 100;

    // weekday sum and its reduction modulo 7
    localparam int          WSUM_BITS    = 12;
    localparam logic [11:0] DAYS_BEFORE_MARCH = 12'd307;
    localparam logic [11:0] MARCH_OFFSET      = 12'd58;
    localparam int          MOD_TOP      = 7;
    localparam int          WEEK_DAYS    = 7;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DAY   = 2'd1,
        ST_BAD_MONTH = 2'd2,
        ST_BAD_YEAR  = 2'd3
    } t_status;

    typedef enum logic {
        OP_DAY_COUNT = 1'b0,
        OP_MDY       = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FWD,
        S_BACK,
        S_CHECK,
        S_MONTH,
        S_MOD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic out_free;
    } t_seq_cmd;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_status;

    // leap rule from the year modulo 400 (which also carries the year modulo 4)
    function automatic logic is_leap400(input logic [8:0] r);
        return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

    function automatic logic [1:0] cent400(input logic [8:0] r);
        logic [1:0] c;
        if (r >= 9'd300)      c = 2'd3;
        else if (r >= 9'd200) c = 2'd2;
        else if (r >= 9'd100) c = 2'd1;
        else                  c = 2'd0;
        return c;
    endfunction

    function automatic logic [8:0] inc400(input logic [8:0] r);
        return (r == CYCLE_YEARS - 9'd1) ? 9'd0 : r + 9'd1;
    endfunction

    function automatic logic [8:0] dec400(input logic [8:0] r);
        return (r == 9'd0) ? CYCLE_YEARS - 9'd1 : r - 9'd1;
    endfunction

    function automatic logic [8:0] year_days(input logic leap);
        return leap ? DAYS_LEAP : DAYS_COMMON;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] s;
        unique case (m)
            4'd1:    s = 9'd1;
            4'd2:    s = 9'd32;
            4'd3:    s = 9'd60;
            4'd4:    s = 9'd91;
            4'd5:    s = 9'd121;
            4'd6:    s = 9'd152;
            4'd7:    s = 9'd182;
            4'd8:    s = 9'd213;
            4'd9:    s = 9'd244;
            4'd10:   s = 9'd274;
            4'd11:   s = 9'd305;
            4'd12:   s = 9'd335;
            default: s = 9'd0;
        endcase
        if (m > FEBRUARY && leap) s = s + 9'd1;
        return s;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
            4'd2:                                        n = leap ? 5'd29 : 5'd28;
            default:                                     n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gdn_addsub.sv
`timescale 1ns / 1ps
`default_nettype none

module gdn_addsub #(
    parameter int W = 24
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic         i_sub,
    output logic      [W-1:0] o_res,
    output logic              o_neg,
    output logic              o_zero
);

    always_comb begin
        o_res  = i_sub ? (i_a - i_b) : (i_a + i_b);
        o_neg  = o_res[W-1];
        o_zero = (o_res == '0);
    end

endmodule

`default_nettype wire

// File: rtl/gdn_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module gdn_seq #(
    parameter int YEAR_BITS      = gdn_pkg::YEAR_BITS_DEF,
    parameter int DAY_COUNT_BITS = gdn_pkg::DAY_COUNT_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire gdn_pkg::t_seq_cmd                i_cmd,
    input  wire logic                             i_operation,
    input  wire logic signed [DAY_COUNT_BITS-1:0] i_day_count,
    input  wire logic        [YEAR_BITS-1:0]      i_year_in,
    input  wire logic        [3:0]                i_month_number,
    input  wire logic        [4:0]                i_day_in_month,
    output gdn_pkg::t_seq_status                  o_status,
    output logic             [YEAR_BITS-1:0]      o_year_out,
    output logic             [8:0]                o_day_of_year,
    output logic             [3:0]                o_month_out,
    output logic             [4:0]                o_day_of_month,
    output logic             [2:0]                o_weekday,
    output logic                                  o_leap_flag,
    output logic             [1:0]                o_status_code
);

    localparam int DW   = DAY_COUNT_BITS + 1;
    localparam int W0   = (DW > YEAR_BITS + 2) ? DW : YEAR_BITS + 2;
    localparam int W    = (W0 > 13) ? W0 : 13;
    localparam int KD   = YEAR_BITS - 8;
    localparam int KMAX = (KD > gdn_pkg::MOD_TOP) ? KD : gdn_pkg::MOD_TOP;
    localparam int KW   = $clog2(KMAX + 1);
    localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

    gdn_pkg::t_state   r_state, n_state;
    gdn_pkg::t_op      r_op, n_op;
    gdn_pkg::t_status  r_status, n_status;
    logic [YEAR_BITS-1:0] r_year, n_year;
    logic signed [DW-1:0] r_day, n_day;
    logic [8:0]        r_r400, n_r400;
    logic [8:0]        r_dy, n_dy;
    logic [3:0]        r_mnum, n_mnum;
    logic [4:0]        r_dmon, n_dmon;
    logic [3:0]        r_month, n_month;
    logic [4:0]        r_dom, n_dom;
    logic [W-1:0]      r_acc, n_acc;
    logic [W-1:0]      r_sub, n_sub;
    logic [KW-1:0]     r_k, n_k;

    logic [W-1:0]      u_a, u_b, u_res;
    logic              u_sub, u_neg, u_zero;

    logic              cur_leap, prev_leap, before_march, ok;
    logic [8:0]        prev_r, wk_r;
    logic [W-1:0]      div_rem;
    logic [YEAR_BITS-1:0] year_mdy;
    logic [3:0]        mcount;
    logic [gdn_pkg::WSUM_BITS-1:0] wsum_base, wsum;

    gdn_addsub #(.W(W)) u_addsub (
        .i_a    (u_a),
        .i_b    (u_b),
        .i_sub  (u_sub),
        .o_res  (u_res),
        .o_neg  (u_neg),
        .o_zero (u_zero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op     <= n_op;
        r_status <= n_status;
        r_year   <= n_year;
        r_day    <= n_day;
        r_r400   <= n_r400;
        r_dy     <= n_dy;
        r_mnum   <= n_mnum;
        r_dmon   <= n_dmon;
        r_month  <= n_month;
        r_dom    <= n_dom;
        r_acc    <= n_acc;
        r_sub    <= n_sub;
        r_k      <= n_k;
    end

    always_comb begin
        cur_leap  = gdn_pkg::is_leap400(r_r400);
        prev_r    = gdn_pkg::dec400(r_r400);
        prev_leap = gdn_pkg::is_leap400(prev_r);

        // two-digit years land in the 1900s
        year_mdy = (i_year_in < YEAR_BITS'(gdn_pkg::TWO_DIGIT))
                 ? i_year_in + YEAR_BITS'(gdn_pkg::YEAR_BIAS) : i_year_in;

        mcount = 4'd1;
        for (int i = 2; i <= gdn_pkg::MONTHS; i++) begin
            if (r_dy >= gdn_pkg::month_start(4'(i), cur_leap)) mcount = mcount + 4'd1;
        end

        // weekday counts from March so the leap day falls at the end of the year
        before_march = r_dy < gdn_pkg::month_start(gdn_pkg::MARCH, cur_leap);
        wk_r = before_march ? prev_r : r_r400;
        wsum_base = gdn_pkg::WSUM_BITS'(r_dy) + gdn_pkg::WSUM_BITS'(wk_r)
                  + gdn_pkg::WSUM_BITS'(wk_r >> 2)
                  - gdn_pkg::WSUM_BITS'(gdn_pkg::cent400(wk_r));
        wsum = before_march ? wsum_base + gdn_pkg::DAYS_BEFORE_MARCH
                            : wsum_base - gdn_pkg::MARCH_OFFSET
                                        - gdn_pkg::WSUM_BITS'(cur_leap);

        n_state  = r_state;
        n_op     = r_op;
        n_status = r_status;
        n_year   = r_year;
        n_day    = r_day;
        n_r400   = r_r400;
        n_dy     = r_dy;
        n_mnum   = r_mnum;
        n_dmon   = r_dmon;
        n_month  = r_month;
        n_dom    = r_dom;
        n_acc    = r_acc;
        n_sub    = r_sub;
        n_k      = r_k;

        u_a   = r_acc;
        u_b   = r_sub;
        u_sub = 1'b1;
        div_rem = u_neg ? r_acc : u_res;

        o_status.idle = (r_state == gdn_pkg::S_IDLE);
        o_status.done = 1'b0;

        unique case (r_state)
            gdn_pkg::S_IDLE: begin
                if (i_cmd.start) begin
                    n_op     = gdn_pkg::t_op'(i_operation);
                    n_year   = (n_op == gdn_pkg::OP_MDY) ? year_mdy : i_year_in;
                    n_day    = DW'(i_day_count);
                    n_mnum   = i_month_number;
                    n_dmon   = i_day_in_month;
                    n_status = gdn_pkg::ST_OK;
                    n_acc    = W'(n_year);
                    n_sub    = W'(gdn_pkg::CYCLE_YEARS) << KD;
                    n_k      = KW'(KD);
                    n_state  = gdn_pkg::S_DIV;
                end
            end
            gdn_pkg::S_DIV: begin
                // restoring reduction of the year modulo 400
                n_acc = div_rem;
                n_sub = r_sub >> 1;
                if (r_k == '0) begin
                    n_r400  = div_rem[8:0];
                    n_state = (r_op == gdn_pkg::OP_DAY_COUNT) ? gdn_pkg::S_FWD
                                                               : gdn_pkg::S_CHECK;
                end else begin
                    n_k = r_k - KW'(1);
                end
            end
            gdn_pkg::S_FWD: begin
                u_a = W'(r_day);
                u_b = W'(gdn_pkg::year_days(cur_leap));
                if (!u_neg && !u_zero) begin
                    if (r_year == YEAR_MAX) begin
                        n_status = gdn_pkg::ST_BAD_YEAR;
                        n_state  = gdn_pkg::S_DONE;
                    end else begin
                        n_day  = u_res[DW-1:0];
                        n_year = r_year + YEAR_BITS'(1);
                        n_r400 = gdn_pkg::inc400(r_r400);
                    end
                end else begin
                    n_state = gdn_pkg::S_BACK;
                end
            end
            gdn_pkg::S_BACK: begin
                u_a   = W'(r_day);
                u_b   = W'(gdn_pkg::year_days(prev_leap));
                u_sub = 1'b0;
                if (r_day[DW-1] || r_day == '0) begin
                    if (r_year <= YEAR_BITS'(1)) begin
                        n_status = gdn_pkg::ST_BAD_YEAR;
                        n_state  = gdn_pkg::S_DONE;
                    end else begin
                        n_day  = u_res[DW-1:0];
                        n_year = r_year - YEAR_BITS'(1);
                        n_r400 = prev_r;
                    end
                end else if (r_year == '0) begin
                    n_status = gdn_pkg::ST_BAD_YEAR;
                    n_state  = gdn_pkg::S_DONE;
                end else begin
                    n_dy    = r_day[8:0];
                    n_state = gdn_pkg::S_MONTH;
                end
            end
            gdn_pkg::S_CHECK: begin
                // the adjusted year always lies in range here
                if (r_mnum < 4'd1 || r_mnum > 4'(gdn_pkg::MONTHS)) begin
                    n_status = gdn_pkg::ST_BAD_MONTH;
                    n_state  = gdn_pkg::S_DONE;
                end else if (r_dmon == 5'd0
                             || r_dmon > gdn_pkg::month_len(r_mnum, cur_leap)) begin
                    n_status = gdn_pkg::ST_BAD_DAY;
                    n_state  = gdn_pkg::S_DONE;
                end else begin
                    n_dy    = 9'(r_dmon) - 9'd1 + gdn_pkg::month_start(r_mnum, cur_leap);
                    n_state = gdn_pkg::S_MONTH;
                end
            end
            gdn_pkg::S_MONTH: begin
                n_month = mcount;
                n_acc   = W'(wsum);
                n_sub   = W'(gdn_pkg::WEEK_DAYS) << gdn_pkg::MOD_TOP;
                n_k     = KW'(gdn_pkg::MOD_TOP);
                n_state = gdn_pkg::S_MOD;
            end
            gdn_pkg::S_MOD: begin
                n_acc = div_rem;
                n_sub = r_sub >> 1;
                n_dom = 5'(r_dy - gdn_pkg::month_start(r_month, cur_leap) + 9'd1);
                if (r_k == '0) begin
                    n_state = gdn_pkg::S_DONE;
                end else begin
                    n_k = r_k - KW'(1);
                end
            end
            gdn_pkg::S_DONE: begin
                // hold until the output register can take the beat
                if (i_cmd.out_free) begin
                    o_status.done = 1'b1;
                    n_state       = gdn_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        ok             = (r_status == gdn_pkg::ST_OK);
        o_year_out     = ok ? r_year : '0;
        o_day_of_year  = ok ? r_dy : '0;
        o_month_out    = ok ? r_month : '0;
        o_day_of_month = ok ? r_dom : '0;
        o_weekday      = ok ? r_acc[2:0] + 3'd1 : '0;
        o_leap_flag    = ok && cur_leap;
        o_status_code  = r_status;
    end

`ifndef NO_ASSERTIONS
    a_done_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.done |-> i_cmd.out_free)
        else $error("result finished while output register is full");

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_status.idle && i_cmd.start) |=> (r_state == gdn_pkg::S_DIV))
        else $error("accepted beat did not start the year reduction");

    a_r400_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gdn_pkg::S_FWD || r_state == gdn_pkg::S_BACK
         || r_state == gdn_pkg::S_MONTH) |-> (r_r400 < gdn_pkg::CYCLE_YEARS))
        else $error("year residue out of range");

    a_dy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gdn_pkg::S_MONTH) |-> (r_dy >= 9'd1 && r_dy <= gdn_pkg::DAYS_LEAP))
        else $error("day of year out of range");

    a_weekday_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gdn_pkg::S_DONE && r_status == gdn_pkg::ST_OK)
        |-> (r_acc < W'(gdn_pkg::WEEK_DAYS)))
        else $error("weekday sum not fully reduced");
`endif

endmodule

`default_nettype wire

// File: rtl/gregorian_date_normalize_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Gregorian date normalizer. Op 0 walks a signed day number relative to January 1
// of a reference year into a year and day of year; op 1 checks a month/day/year
// (years below 100 map to the 1900s). Each beat returns year, day of year, month,
// day of month, weekday (Monday = 1), leap flag and status; on any error all other
// fields read zero. One item at a time: op 0 walks the day number year by year, one
// year per cycle through the single shared adder (which also does the modulo-400 and
// modulo-7 reductions); the years crossed reach about 2900 for the extreme 21-bit
// day counts. The input stalls while an item is in work; a finished result waits in
// the output register while the next beat is accepted.
module gregorian_date_normalize_unit #(
    parameter int YEAR_BITS      = gdn_pkg::YEAR_BITS_DEF,
    parameter int DAY_COUNT_BITS = gdn_pkg::DAY_COUNT_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic                             i_operation,
    input  wire logic signed [DAY_COUNT_BITS-1:0] i_day_count,
    input  wire logic        [YEAR_BITS-1:0]      i_year_in,
    input  wire logic        [3:0]                i_month_number,
    input  wire logic        [4:0]                i_day_in_month,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic             [YEAR_BITS-1:0]      o_year_out,
    output logic             [8:0]                o_day_of_year,
    output logic             [3:0]                o_month_out,
    output logic             [4:0]                o_day_of_month,
    output logic             [2:0]                o_weekday,
    output logic                                  o_leap_flag,
    output logic             [1:0]                o_status
);

    gdn_pkg::t_seq_cmd    seq_cmd;
    gdn_pkg::t_seq_status seq_st;

    logic [YEAR_BITS-1:0] s_year;
    logic [8:0]           s_doy;
    logic [3:0]           s_month;
    logic [4:0]           s_dom;
    logic [2:0]           s_wday;
    logic                 s_leap;
    logic [1:0]           s_status;

    logic                 r_out_valid;
    logic [YEAR_BITS-1:0] r_year;
    logic [8:0]           r_doy;
    logic [3:0]           r_month;
    logic [4:0]           r_dom;
    logic [2:0]           r_wday;
    logic                 r_leap;
    logic [1:0]           r_status;

    always_comb begin
        seq_cmd.start    = i_valid && seq_st.idle;
        seq_cmd.out_free = !r_out_valid || !i_stall;
        o_stall          = !seq_st.idle;
    end

    gdn_seq #(
        .YEAR_BITS      (YEAR_BITS),
        .DAY_COUNT_BITS (DAY_COUNT_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (seq_cmd),
        .i_operation    (i_operation),
        .i_day_count    (i_day_count),
        .i_year_in      (i_year_in),
        .i_month_number (i_month_number),
        .i_day_in_month (i_day_in_month),
        .o_status       (seq_st),
        .o_year_out     (s_year),
        .o_day_of_year  (s_doy),
        .o_month_out    (s_month),
        .o_day_of_month (s_dom),
        .o_weekday      (s_wday),
        .o_leap_flag    (s_leap),
        .o_status_code  (s_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_st.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (seq_st.done) begin
            r_year   <= s_year;
            r_doy    <= s_doy;
            r_month  <= s_month;
            r_dom    <= s_dom;
            r_wday   <= s_wday;
            r_leap   <= s_leap;
            r_status <= s_status;
        end
    end

    always_comb begin
        o_valid        = r_out_valid;
        o_year_out     = r_year;
        o_day_of_year  = r_doy;
        o_month_out    = r_month;
        o_day_of_month = r_dom;
        o_weekday      = r_wday;
        o_leap_flag    = r_leap;
        o_status       = r_status;
    end

endmodule

`default_nettype wire

// File: bench/gdn_result_checker.sv
`timescale 1ns / 1ps

module gdn_result_checker #(
    parameter int YEAR_BITS      = gdn_pkg::YEAR_BITS_DEF,
    parameter int DAY_COUNT_BITS = gdn_pkg::DAY_COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic                             i_req_stall,
    input  logic                             i_req_operation,
    input  logic signed [DAY_COUNT_BITS-1:0] i_req_day_count,
    input  logic        [YEAR_BITS-1:0]      i_req_year_in,
    input  logic        [3:0]                i_req_month_number,
    input  logic        [4:0]                i_req_day_in_month,
    input  logic                             i_rsp_valid,
    input  logic                             i_rsp_stall,
    input  logic        [YEAR_BITS-1:0]      i_year_out,
    input  logic        [8:0]                i_day_of_year,
    input  logic        [3:0]                i_month_out,
    input  logic        [4:0]                i_day_of_month,
    input  logic        [2:0]                i_weekday,
    input  logic                             i_leap_flag,
    input  logic        [1:0]                i_status,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam longint TOP_YEAR = (longint'(1) << YEAR_BITS) - 1;
    localparam int MONTH_FIRST [12] = '{1, 32, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};
    localparam int MONTH_DAYS  [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [YEAR_BITS-1:0] year;
        logic [8:0]           day_of_year;
        logic [3:0]           month;
        logic [4:0]           day_of_month;
        logic [2:0]           weekday;
        logic                 leap;
        gdn_pkg::t_status     status;
    } t_date_beat;

    t_date_beat expected_dates [$];
    int         mismatches = 0;

    function automatic bit leap_year(longint y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic longint days_in_year(longint y);
        return leap_year(y) ? 366 : 365;
    endfunction

    function automatic longint month_first(int m, bit lp);
        return MONTH_FIRST[m-1] + ((m > 2 && lp) ? 1 : 0);
    endfunction

    function automatic t_date_beat normalize_date(
        logic                             op,
        logic signed [DAY_COUNT_BITS-1:0] dc,
        logic        [YEAR_BITS-1:0]      yr,
        logic        [3:0]                mo,
        logic        [4:0]                dm
    );
        t_date_beat r;
        longint     y, d, len, dd, yn, dn, wd;
        int         m;
        bit         lp;
        r = '0;
        y = yr;
        if (op == gdn_pkg::OP_DAY_COUNT) begin
            d = dc;
            while (d > days_in_year(y)) begin
                if (y >= TOP_YEAR) begin
                    r.status = gdn_pkg::ST_BAD_YEAR;
                    return r;
                end
                d = d - days_in_year(y);
                y = y + 1;
            end
            while (d <= 0) begin
                if (y <= 1) begin
                    r.status = gdn_pkg::ST_BAD_YEAR;
                    return r;
                end
                y = y - 1;
                d = d + days_in_year(y);
            end
            if (y < 1) begin
                r.status = gdn_pkg::ST_BAD_YEAR;
                return r;
            end
        end else begin
            // two-digit years land in the 1900s
            if (y < 100) y = y + 1900;
            m = mo;
            if (m < 1 || m > 12) begin
                r.status = gdn_pkg::ST_BAD_MONTH;
                return r;
            end
            lp  = leap_year(y);
            len = MONTH_DAYS[m-1] + ((m == 2 && lp) ? 1 : 0);
            dd  = dm;
            if (dd < 1 || dd > len) begin
                r.status = gdn_pkg::ST_BAD_DAY;
                return r;
            end
            if (y < 1 || y > TOP_YEAR) begin
                r.status = gdn_pkg::ST_BAD_YEAR;
                return r;
            end
            d = dd - 1 + month_first(m, lp);
        end

        lp = leap_year(y);
        m  = 12;
        while (m > 1 && month_first(m, lp) > d) m--;
        // January and February count as months of the previous year for the weekday
        if (d < month_first(3, lp)) begin
            yn = y - 1;
            dn = 307;
        end else begin
            yn = y;
            dn = lp ? -59 : -58;
        end
        wd = (dn + d + yn + yn / 4 + yn / 400 - yn / 100) % 7 + 1;

        r.year         = YEAR_BITS'(y);
        r.day_of_year  = 9'(d);
        r.month        = 4'(m);
        r.day_of_month = 5'(d - month_first(m, lp) + 1);
        r.weekday      = 3'(wd);
        r.leap         = lp;
        r.status       = gdn_pkg::ST_OK;
        return r;
    endfunction

    function automatic int field_mismatch(string field, longint want, longint got);
        if (want == got) return 0;
        $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_date_beat want;
        if (i_rst_n) begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_dates.size() == 0) begin
                    $display("%0t ns: result beat expected none, actual year %0d day %0d status %0d",
                             $time, i_year_out, i_day_of_year, i_status);
                    mismatches++;
                end else begin
                    want = expected_dates.pop_front();
                    mismatches += field_mismatch("year_out", want.year, i_year_out);
                    mismatches += field_mismatch("day_of_year", want.day_of_year, i_day_of_year);
                    mismatches += field_mismatch("month_out", want.month, i_month_out);
                    mismatches += field_mismatch("day_of_month", want.day_of_month,
                                                 i_day_of_month);
                    mismatches += field_mismatch("weekday", want.weekday, i_weekday);
                    mismatches += field_mismatch("leap_flag", want.leap, i_leap_flag);
                    mismatches += field_mismatch("status", want.status, i_status);
                end
            end
            if (i_req_valid && !i_req_stall)
                expected_dates.push_back(normalize_date(i_req_operation, i_req_day_count,
                                                        i_req_year_in, i_req_month_number,
                                                        i_req_day_in_month));
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_dates.size();
    end

endmodule

// File: bench/gregorian_date_normalize_unit_tb.sv
`timescale 1ns / 1ps

module gregorian_date_normalize_unit_tb;

    localparam int YEAR_BITS      = gdn_pkg::YEAR_BITS_DEF;
    localparam int DAY_COUNT_BITS = gdn_pkg::DAY_COUNT_BITS_DEF;
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int IDLE_PCT       = 21;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 4 * (YEAR_BITS + 5);
    // covers the longest year walk (about 2900 years) and the receiver hold-off
    localparam int WATCHDOG_LIMIT = 30000;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             req_valid;
    logic                             req_stall;
    gdn_pkg::t_op                     req_operation;
    logic signed [DAY_COUNT_BITS-1:0] req_day_count;
    logic        [YEAR_BITS-1:0]      req_year_in;
    logic        [3:0]                req_month_number;
    logic        [4:0]                req_day_in_month;
    logic                             rsp_valid;
    logic                             rsp_stall;
    logic        [YEAR_BITS-1:0]      year_out;
    logic        [8:0]                day_of_year;
    logic        [3:0]                month_out;
    logic        [4:0]                day_of_month;
    logic        [2:0]                weekday;
    logic                             leap_flag;
    logic        [1:0]                status;

    int   fail_count;
    int   pending;
    int   quiet_cycles;
    logic calm_out;
    logic pressure_go;
    bit   calm_in;

    gregorian_date_normalize_unit #(
        .YEAR_BITS     (YEAR_BITS),
        .DAY_COUNT_BITS(DAY_COUNT_BITS)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (req_valid),
        .o_stall       (req_stall),
        .i_operation   (req_operation),
        .i_day_count   (req_day_count),
        .i_year_in     (req_year_in),
        .i_month_number(req_month_number),
        .i_day_in_month(req_day_in_month),
        .o_valid       (rsp_valid),
        .i_stall       (rsp_stall),
        .o_year_out    (year_out),
        .o_day_of_year (day_of_year),
        .o_month_out   (month_out),
        .o_day_of_month(day_of_month),
        .o_weekday     (weekday),
        .o_leap_flag   (leap_flag),
        .o_status      (status)
    );

    gdn_result_checker #(
        .YEAR_BITS     (YEAR_BITS),
        .DAY_COUNT_BITS(DAY_COUNT_BITS)
    ) u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_req_valid       (req_valid),
        .i_req_stall       (req_stall),
        .i_req_operation   (req_operation),
        .i_req_day_count   (req_day_count),
        .i_req_year_in     (req_year_in),
        .i_req_month_number(req_month_number),
        .i_req_day_in_month(req_day_in_month),
        .i_rsp_valid       (rsp_valid),
        .i_rsp_stall       (rsp_stall),
        .i_year_out        (year_out),
        .i_day_of_year     (day_of_year),
        .i_month_out       (month_out),
        .i_day_of_month    (day_of_month),
        .i_weekday         (weekday),
        .i_leap_flag       (leap_flag),
        .i_status          (status),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always #CLK_HALF clk = ~clk;

    // drive one request beat and hold it until the block takes it
    task automatic send_date(input gdn_pkg::t_op op, input int dc, input int yr, input int mo,
                             input int dm);
        while (!calm_in && $urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid        <= 1'b1;
        req_operation    <= op;
        req_day_count    <= DAY_COUNT_BITS'(dc);
        req_year_in      <= YEAR_BITS'(yr);
        req_month_number <= 4'(mo);
        req_day_in_month <= 5'(dm);
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic send_random_date();
        gdn_pkg::t_op op;
        int  dc, yr, mo, dm, pick;
        op   = $urandom_range(1) ? gdn_pkg::OP_MDY : gdn_pkg::OP_DAY_COUNT;
        pick = $urandom_range(19);
        // mostly short walks around year boundaries, a few across the whole range
        if (pick < 11)      dc = int'($urandom_range(800)) - 400;
        else if (pick < 17) dc = int'($urandom_range(100000)) - 50000;
        else                dc = int'($urandom());
        pick = $urandom_range(9);
        if (pick < 2)      yr = $urandom_range(99);
        else if (pick < 8) yr = $urandom_range(9999, 100);
        else               yr = $urandom_range((1 << YEAR_BITS) - 1);
        mo = ($urandom_range(9) < 8) ? $urandom_range(12, 1) : $urandom_range(15);
        dm = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(28, 1);
        send_date(op, dc, yr, mo, dm);
    endtask

    // receiver: random stalls, one long hold-off when asked
    initial begin : receiver
        bit held;
        held      = 1'b0;
        rsp_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (pressure_go && !held) begin
                held = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
            end else begin
                rsp_stall <= !calm_out && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rst_n            = 1'b0;
        req_valid        = 1'b0;
        req_operation    = gdn_pkg::OP_DAY_COUNT;
        req_day_count    = '0;
        req_year_in      = '0;
        req_month_number = '0;
        req_day_in_month = '0;
        calm_out         = 1'b0;
        pressure_go      = 1'b0;
        calm_in          = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // day counts: year edges, leap days, both walk directions, range limits
        send_date(gdn_pkg::OP_DAY_COUNT, 1, 2000, 15, 31);
        send_date(gdn_pkg::OP_DAY_COUNT, 366, 2000, 0, 0);
        send_date(gdn_pkg::OP_DAY_COUNT, 366, 2001, 7, 9);
        send_date(gdn_pkg::OP_DAY_COUNT, 0, 2000, 0, 0);
        send_date(gdn_pkg::OP_DAY_COUNT, 60, 2000, 0, 0);
        send_date(gdn_pkg::OP_DAY_COUNT, 60, 1900, 0, 0);
        send_date(gdn_pkg::OP_DAY_COUNT, 1, 1, 0, 0);
        send_date(gdn_pkg::OP_DAY_COUNT, 0, 1, 0, 0);
        send_date(gdn_pkg::OP_DAY_COUNT, 1, 0, 0, 0);
        send_date(gdn_pkg::OP_DAY_COUNT, -1048576, 9999, 0, 0);
        send_date(gdn_pkg::OP_DAY_COUNT, 1048575, 0, 15, 31);
        send_date(gdn_pkg::OP_DAY_COUNT, 365, 16383, 0, 0);
        send_date(gdn_pkg::OP_DAY_COUNT, 1048575, 16383, 0, 0);
        // calendar dates: month before day check, February rules, two-digit years
        send_date(gdn_pkg::OP_MDY, -1, 0, 0, 0);
        send_date(gdn_pkg::OP_MDY, -1, 16383, 15, 31);
        send_date(gdn_pkg::OP_MDY, 0, 2000, 13, 1);
        send_date(gdn_pkg::OP_MDY, 0, 1900, 2, 29);
        send_date(gdn_pkg::OP_MDY, 0, 2000, 2, 29);
        send_date(gdn_pkg::OP_MDY, 0, 96, 2, 29);
        send_date(gdn_pkg::OP_MDY, 0, 0, 2, 29);
        send_date(gdn_pkg::OP_MDY, 0, 2024, 4, 31);
        send_date(gdn_pkg::OP_MDY, 0, 2024, 1, 0);
        send_date(gdn_pkg::OP_MDY, 0, 16383, 12, 31);
        send_date(gdn_pkg::OP_MDY, 0, 99, 1, 1);
        send_date(gdn_pkg::OP_MDY, 0, 100, 3, 1);

        repeat (40) send_random_date();

        calm_in = 1'b1;
        calm_out <= 1'b1;
        repeat (30) send_random_date();

        // fill the block while the receiver holds off
        calm_out    <= 1'b0;
        pressure_go <= 1'b1;
        repeat (10) send_random_date();

        calm_in = 1'b0;
        repeat (35) send_random_date();
        req_valid <= 1'b0;

        // let the last accepted beat reach the pending count
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/gdn_pkg.sv
rtl/gdn_addsub.sv
rtl/gdn_seq.sv
rtl/gregorian_date_normalize_unit.sv
bench/gdn_result_checker.sv
bench/gregorian_date_normalize_unit_tb.sv
